>>> hdl/ptsm_pkg.sv
// Shared types, constants and lookup tables for the path turn smoothness metrics block.
package ptsm_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int CORDIC_STEPS_MAX = 24;
	localparam int QUEUE_DEPTH = 2;
	localparam int DIV_STEPS = 47;

	localparam logic signed [27:0] PI_Q24 = 28'sd52707179;
	localparam logic signed [16:0] PI_Q13 = 17'sd25736;
	localparam logic signed [16:0] TWO_PI_Q13 = 17'sd51472;
	localparam logic [19:0] INV_GAIN_Q20 = 20'd636752;
	localparam logic [39:0] LEN_MAX = 40'hFF_FFFF_FFFF;

	localparam logic [15:0] SMOOTH_RESET = 16'd4096;
	localparam logic [14:0] TURN_RESET = 15'd6434;

	localparam logic ADDR_SMOOTH = 1'b0;
	localparam logic ADDR_TURN = 1'b1;

	// One classified point as handed from the front to the back.
	typedef struct packed {
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic seg_ok;
		logic last;
		logic few;
	} point_entry_t;

	function automatic logic signed [27:0] atan_q24(input logic [4:0] idx);
		logic signed [27:0] r;
		unique case (idx)
			5'd0: r = 28'sd13176795;
			5'd1: r = 28'sd7778716;
			5'd2: r = 28'sd4110060;
			5'd3: r = 28'sd2086331;
			5'd4: r = 28'sd1047214;
			5'd5: r = 28'sd524117;
			5'd6: r = 28'sd262123;
			5'd7: r = 28'sd131069;
			5'd8: r = 28'sd65536;
			5'd9: r = 28'sd32768;
			5'd10: r = 28'sd16384;
			5'd11: r = 28'sd8192;
			5'd12: r = 28'sd4096;
			5'd13: r = 28'sd2048;
			5'd14: r = 28'sd1024;
			5'd15: r = 28'sd512;
			5'd16: r = 28'sd256;
			5'd17: r = 28'sd128;
			5'd18: r = 28'sd64;
			5'd19: r = 28'sd32;
			5'd20: r = 28'sd16;
			5'd21: r = 28'sd8;
			5'd22: r = 28'sd4;
			5'd23: r = 28'sd2;
			default: r = 28'sd0;
		endcase
		return r;
	endfunction

endpackage

>>> hdl/path_turn_smoothness_metrics.sv
// Top level of the path turn smoothness metrics block with its register port.
//
// Points of a planar path enter through a queue-style input: a transaction
// takes place when push is high and full is low. The point marked with
// last_point closes the path and produces exactly one result; other points
// produce none. Results leave through a queue-style output: while empty is
// low the result ports hold the oldest result, and pop takes it.
// The front accepts a point and parks it in a two-entry queue.
// The back works one point at a time: a point that forms a segment passes
// through the iterative CORDIC rotator, two multiply states, accumulation
// and a finish state; a point that does not goes straight to the finish
// state. A closing point of a path of three or more points then runs the
// iterative divide and the output state; on a shorter path only the
// output state follows the finish state.
// Reset clears all path state, sets the limit registers to their defaults
// and empties both queues. When the receiver stalls, the result register
// holds its result; the back waits, the queue fills and full rises.
// The limit registers sit at byte addresses 0 and 4 of the APB port and
// should only be written while the block is idle.
module path_turn_smoothness_metrics #(
	parameter int CORDIC_STEPS = ptsm_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic               last_point,
	output logic               empty,
	input  logic               pop,
	output logic [15:0]        turn_per_length,
	output logic [14:0]        largest_turn,
	output logic [39:0]        path_length,
	output logic               too_curvy,
	output logic               too_few_points,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [15:0] smooth_q;
	logic [14:0] turn_q;
	logic q_full;
	logic q_empty;
	logic wr_en;
	logic rd_en;
	ptsm_pkg::point_entry_t wr_data;
	ptsm_pkg::point_entry_t rd_data;

	// The port never inserts wait states.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == ptsm_pkg::ADDR_TURN) ? {17'b0, turn_q} : {16'b0, smooth_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= ptsm_pkg::SMOOTH_RESET;
			turn_q <= ptsm_pkg::TURN_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == ptsm_pkg::ADDR_TURN) begin
				turn_q <= pwdata[14:0];
			end else begin
				smooth_q <= pwdata[15:0];
			end
		end
	end

	assign full = q_full;

	ptsm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.point_x   (point_x),
		.point_y   (point_y),
		.last_point(last_point),
		.q_full    (q_full),
		.wr_en     (wr_en),
		.wr_data   (wr_data)
	);

	ptsm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.wr_data(wr_data),
		.q_full (q_full),
		.rd_en  (rd_en),
		.rd_data(rd_data),
		.q_empty(q_empty)
	);

	ptsm_back #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.rd_data         (rd_data),
		.rd_en           (rd_en),
		.smoothness_limit(smooth_q),
		.turn_limit      (turn_q),
		.pop             (pop),
		.empty           (empty),
		.turn_per_length (turn_per_length),
		.largest_turn    (largest_turn),
		.path_length     (path_length),
		.too_curvy       (too_curvy),
		.too_few_points  (too_few_points)
	);

endmodule

>>> hdl/ptsm_queue.sv
// Two-entry queue of classified points between the front and the back.
module ptsm_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  ptsm_pkg::point_entry_t  wr_data,
	output logic                    q_full,
	input  logic                    rd_en,
	output ptsm_pkg::point_entry_t  rd_data,
	output logic                    q_empty
);

	ptsm_pkg::point_entry_t mem_q [ptsm_pkg::QUEUE_DEPTH];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;
	logic do_wr;
	logic do_rd;

	assign q_full = (cnt_q == 2'(ptsm_pkg::QUEUE_DEPTH));
	assign q_empty = (cnt_q == 2'd0);
	assign do_wr = wr_en && !q_full;
	assign do_rd = rd_en && !q_empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

>>> hdl/ptsm_front.sv
// Front end: accepts points, forms segment deltas and classifies each point.
module ptsm_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic signed [31:0]      point_x,
	input  logic signed [31:0]      point_y,
	input  logic                    last_point,
	input  logic                    q_full,
	output logic                    wr_en,
	output ptsm_pkg::point_entry_t  wr_data
);

	logic signed [31:0] prior_x_q;
	logic signed [31:0] prior_y_q;
	logic [1:0] seen_q;
	logic [1:0] seen_next;
	logic signed [32:0] dx;
	logic signed [32:0] dy;

	assign dx = 33'(point_x) - 33'(prior_x_q);
	assign dy = 33'(point_y) - 33'(prior_y_q);
	assign seen_next = (seen_q == 2'd3) ? 2'd3 : seen_q + 2'd1;

	assign wr_en = push && !q_full;
	assign wr_data.dx = dx;
	assign wr_data.dy = dy;
	assign wr_data.seg_ok = (seen_q != 2'd0) && !((dx == 33'sd0) && (dy == 33'sd0));
	assign wr_data.last = last_point;
	assign wr_data.few = (seen_next != 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_x_q <= '0;
			prior_y_q <= '0;
			seen_q <= 2'd0;
		end else if (wr_en) begin
			// The marked point ends the path, so the next point starts fresh.
			if (last_point) begin
				prior_x_q <= '0;
				prior_y_q <= '0;
				seen_q <= 2'd0;
			end else begin
				prior_x_q <= point_x;
				prior_y_q <= point_y;
				seen_q <= seen_next;
			end
		end
	end

endmodule

>>> hdl/ptsm_back.sv
// Back end: iterative CORDIC, accumulation, iterative divide and the result register.
module ptsm_back #(
	parameter int CORDIC_STEPS = ptsm_pkg::CORDIC_STEPS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_empty,
	input  ptsm_pkg::point_entry_t  rd_data,
	output logic                    rd_en,
	input  logic [15:0]             smoothness_limit,
	input  logic [14:0]             turn_limit,
	input  logic                    pop,
	output logic                    empty,
	output logic [15:0]             turn_per_length,
	output logic [14:0]             largest_turn,
	output logic [39:0]             path_length,
	output logic                    too_curvy,
	output logic                    too_few_points
);

	localparam int STEPS = (CORDIC_STEPS > ptsm_pkg::CORDIC_STEPS_MAX) ?
		ptsm_pkg::CORDIC_STEPS_MAX : CORDIC_STEPS;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_ROT  = 9'b000000010,
		ST_MUL1 = 9'b000000100,
		ST_MUL2 = 9'b000001000,
		ST_ACC  = 9'b000010000,
		ST_SUM  = 9'b000100000,
		ST_FIN  = 9'b001000000,
		ST_DIV  = 9'b010000000,
		ST_OUT  = 9'b100000000
	} back_state_t;

	back_state_t state_q;
	ptsm_pkg::point_entry_t cur_q;

	logic signed [43:0] x_q;
	logic signed [43:0] y_q;
	logic signed [27:0] z_q;
	logic [4:0] rot_cnt_q;
	logic [41:0] p_lo_q;
	logic [41:0] p_hi_q;
	logic [35:0] sl_q;
	logic signed [15:0] heading_q;
	logic [14:0] t_q;

	logic signed [15:0] prior_heading_q;
	logic prior_ok_q;
	logic [31:0] turn_sum_q;
	logic [14:0] turn_peak_q;
	logic [39:0] length_q;

	logic [46:0] num_q;
	logic [39:0] rem_q;
	logic [39:0] divisor_q;
	logic [5:0] div_cnt_q;

	logic out_valid_q;
	logic [15:0] tpl_q;
	logic [14:0] peak_out_q;
	logic [39:0] len_out_q;
	logic curvy_q;
	logic few_q;

	// Combinational helpers.
	logic signed [43:0] x0;
	logic signed [43:0] y0;
	logic signed [43:0] xs;
	logic signed [43:0] ys;
	logic signed [27:0] zr;
	logic signed [16:0] h17;
	logic signed [16:0] h1;
	logic signed [16:0] h2;
	logic signed [16:0] d0;
	logic signed [16:0] d1;
	logic signed [16:0] d2;
	logic signed [16:0] dabs;
	logic [63:0] prod;
	logic [40:0] len_add;
	logic [32:0] turn_add;
	logic [40:0] trial;
	logic ge;

	assign rd_en = (state_q == ST_IDLE) && !q_empty;

	assign x0 = {{3{rd_data.dx[32]}}, rd_data.dx, 8'b0};
	assign y0 = {{3{rd_data.dy[32]}}, rd_data.dy, 8'b0};
	assign xs = x_q >>> rot_cnt_q;
	assign ys = y_q >>> rot_cnt_q;

	always_comb begin
		zr = z_q + 28'sd1024;
		h17 = zr[27:11];
		h1 = (h17 > ptsm_pkg::PI_Q13) ? h17 - ptsm_pkg::TWO_PI_Q13 : h17;
		h2 = (h1 <= -ptsm_pkg::PI_Q13) ? h1 + ptsm_pkg::TWO_PI_Q13 : h1;
	end

	always_comb begin
		d0 = 17'(heading_q) - 17'(prior_heading_q);
		d1 = (d0 > ptsm_pkg::PI_Q13) ? d0 - ptsm_pkg::TWO_PI_Q13 : d0;
		d2 = (d1 <= -ptsm_pkg::PI_Q13) ? d1 + ptsm_pkg::TWO_PI_Q13 : d1;
		dabs = (d2 < 17'sd0) ? -d2 : d2;
	end

	assign prod = {22'b0, p_lo_q} + {p_hi_q, 22'b0} + 64'(1 << 27);
	assign len_add = {1'b0, length_q} + 41'(sl_q);
	assign turn_add = {1'b0, turn_sum_q} + 33'(t_q);
	assign trial = {rem_q, num_q[46]};
	assign ge = (trial >= {1'b0, divisor_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_q <= '0;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
			rot_cnt_q <= '0;
			p_lo_q <= '0;
			p_hi_q <= '0;
			sl_q <= '0;
			heading_q <= '0;
			t_q <= '0;
			prior_heading_q <= '0;
			prior_ok_q <= 1'b0;
			turn_sum_q <= '0;
			turn_peak_q <= '0;
			length_q <= '0;
			num_q <= '0;
			rem_q <= '0;
			divisor_q <= '0;
			div_cnt_q <= '0;
			out_valid_q <= 1'b0;
			tpl_q <= '0;
			peak_out_q <= '0;
			len_out_q <= '0;
			curvy_q <= 1'b0;
			few_q <= 1'b0;
		end else begin
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						cur_q <= rd_data;
						rot_cnt_q <= '0;
						// Fold the left half plane onto the right before rotating.
						if (rd_data.dx[32]) begin
							x_q <= -x0;
							y_q <= -y0;
							z_q <= rd_data.dy[32] ? -ptsm_pkg::PI_Q24 : ptsm_pkg::PI_Q24;
						end else begin
							x_q <= x0;
							y_q <= y0;
							z_q <= '0;
						end
						state_q <= rd_data.seg_ok ? ST_ROT : ST_FIN;
					end
				end
				ST_ROT: begin
					if (y_q > 44'sd0) begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + ptsm_pkg::atan_q24(rot_cnt_q);
					end else begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - ptsm_pkg::atan_q24(rot_cnt_q);
					end
					rot_cnt_q <= rot_cnt_q + 5'd1;
					if (rot_cnt_q == 5'(STEPS - 1)) begin
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: begin
					p_lo_q <= 42'(x_q[21:0]) * 42'(ptsm_pkg::INV_GAIN_Q20);
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					p_hi_q <= 42'(x_q[43:22]) * 42'(ptsm_pkg::INV_GAIN_Q20);
					heading_q <= h2[15:0];
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					sl_q <= prod[63:28];
					t_q <= dabs[14:0];
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					length_q <= len_add[40] ? ptsm_pkg::LEN_MAX : len_add[39:0];
					if (prior_ok_q) begin
						turn_sum_q <= turn_add[32] ? 32'hFFFF_FFFF : turn_add[31:0];
						if (t_q > turn_peak_q) begin
							turn_peak_q <= t_q;
						end
					end
					prior_heading_q <= heading_q;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					prior_ok_q <= cur_q.seg_ok;
					div_cnt_q <= '0;
					rem_q <= '0;
					num_q <= {turn_sum_q, 15'b0};
					divisor_q <= (length_q == 40'd0) ? 40'd1 : length_q;
					if (!cur_q.last) begin
						state_q <= ST_IDLE;
					end else if (cur_q.few) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= ge ? 40'(trial - {1'b0, divisor_q}) : trial[39:0];
					num_q <= {num_q[45:0], ge};
					div_cnt_q <= div_cnt_q + 6'd1;
					if (div_cnt_q == 6'(ptsm_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						few_q <= cur_q.few;
						if (cur_q.few) begin
							tpl_q <= '0;
							peak_out_q <= '0;
							len_out_q <= '0;
							curvy_q <= 1'b0;
						end else begin
							tpl_q <= (|num_q[46:16]) ? 16'hFFFF : num_q[15:0];
							peak_out_q <= turn_peak_q;
							len_out_q <= length_q;
							curvy_q <= (num_q > 47'(smoothness_limit)) ||
								(turn_peak_q > turn_limit);
						end
						prior_heading_q <= '0;
						prior_ok_q <= 1'b0;
						turn_sum_q <= '0;
						turn_peak_q <= '0;
						length_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign empty = !out_valid_q;
	assign turn_per_length = tpl_q;
	assign largest_turn = peak_out_q;
	assign path_length = len_out_q;
	assign too_curvy = curvy_q;
	assign too_few_points = few_q;

endmodule

>>> hdl/ptsm_checker.sv
// Port-level checker for the path turn smoothness metrics block, bound to the top level.
module ptsm_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [15:0] turn_per_length,
	input logic [14:0] largest_turn,
	input logic [39:0] path_length,
	input logic        too_curvy,
	input logic        too_few_points,
	input logic        pready
);

	// A short path reports all metrics as zero.
	a_few_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && too_few_points) |-> (turn_per_length == 16'd0 &&
		largest_turn == 15'd0 && path_length == 40'd0 && !too_curvy))
		else $error("short path result carries nonzero metrics");

	// A single turn never exceeds pi in magnitude.
	a_peak_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (largest_turn <= 15'd25736))
		else $error("largest turn beyond pi");

	// A waiting result that is not taken stays on the ports.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(path_length) &&
		$stable(turn_per_length)))
		else $error("result changed while waiting");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind path_turn_smoothness_metrics ptsm_port_checks u_ptsm_port_checks (
	.clk            (clk),
	.arst_n         (arst_n),
	.empty          (empty),
	.pop            (pop),
	.turn_per_length(turn_per_length),
	.largest_turn   (largest_turn),
	.path_length    (path_length),
	.too_curvy      (too_curvy),
	.too_few_points (too_few_points),
	.pready         (pready)
);
